### sv/tfsc_pkg.sv
// ----------------------------------------------------------------------------
// tfsc_pkg: shared types and constants of the thermal fan speed controller
// Item formats, operation codes, register indexes and the fixed constants of
// the fan curve and the PWM duty mapping.
// ----------------------------------------------------------------------------
package tfsc_pkg;

  // Width of the shared adder, enough for the curve numerator with sign.
  localparam int AluW = 23;

  typedef enum logic [1:0] {
    OpSample   = 2'd0,
    OpToggle   = 2'd1,
    OpDecrease = 2'd2,
    OpIncrease = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegOnTemp    = 3'd0,
    RegOffTemp   = 3'd1,
    RegFullTemp  = 3'd2,
    RegHighFloor = 3'd3,
    RegLowFloor  = 3'd4,
    RegStep      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic signed [11:0] driver_temp;
    logic signed [11:0] regulator_temp;
  } in_item_t;

  typedef struct packed {
    logic [6:0] fan_percent;
    logic [7:0] pwm_duty;
    logic       manual_active;
    logic       auto_running;
  } out_item_t;

  // Reset values of the configuration registers.
  localparam logic signed [11:0] OnTempRst   = 12'sd592;
  localparam logic signed [11:0] OffTempRst  = 12'sd528;
  localparam logic signed [11:0] FullTempRst = 12'sd720;
  localparam logic [6:0]         HighFloorRst = 7'd50;
  localparam logic [6:0]         LowFloorRst  = 7'd30;
  localparam logic [6:0]         StepRst      = 7'd20;

  localparam logic [6:0]  MaxSpeed = 7'd100;
  localparam logic [7:0]  PwmBase  = 8'd100;
  localparam logic [7:0]  PwmSpan  = 8'd155;
  // ceil(2^22 / 100): exact quotient by 100 for all products up to 15500.
  localparam logic [15:0] PwmRecip = 16'd41944;

endpackage

### sv/tfsc_alu.sv
// ----------------------------------------------------------------------------
// tfsc_alu: shared adder and subtractor of the fan speed controller
// One two's complement adder that the sequencer uses for the temperature
// compares and differences, the curve sum and every division step.
// ----------------------------------------------------------------------------
module tfsc_alu (
  input  logic [tfsc_pkg::AluW-1:0] a_i,
  input  logic [tfsc_pkg::AluW-1:0] b_i,
  input  logic                      sub_i,
  output logic [tfsc_pkg::AluW-1:0] res_o,
  output logic                      neg_o
);
  import tfsc_pkg::*;

  logic [AluW-1:0] b_op;

  assign b_op  = sub_i ? ~b_i : b_i;
  assign res_o = a_i + b_op + {{(AluW-1){1'b0}}, sub_i};
  assign neg_o = res_o[AluW-1];

endmodule

### sv/thermal_fan_speed_controller.sv
// ----------------------------------------------------------------------------
// thermal_fan_speed_controller: hysteresis fan curve controller
// Turns temperature samples and manual key items into a fan speed in percent
// and a PWM duty, with on/off hysteresis and two linear speed curves.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per handshake: either a pair of
//   sensor temperatures (op sample) or a manual key (toggle, decrease,
//   increase). Every accepted item yields exactly one output item with the
//   speed, the PWM duty and the mode flags after the update.
//   The input side is stalled while an item is in work. A key item or a
//   sample ignored in manual mode goes from decode straight to the output
//   state, a sample that stops the fan or lands between the thresholds
//   while it is off passes the on and off compares first, and a sample on
//   a curve then forms the span, both products, their sum and the curve
//   quotient, by restoring division on the one shared adder, one quotient
//   bit per cycle. The next item is taken the cycle after the output state.
//   The output register parts the two sides: a new input item is taken while
//   a finished one waits, and a sequence only stalls in its last state if the
//   receiver still holds the previous output item.
//   Configuration writes are always ready and take effect on the next cycle;
//   they are meant to be made only while the block is idle.
//   Reset clears the speed and both mode flags, loads the default thresholds,
//   floors and step and empties the output register.
// ----------------------------------------------------------------------------
module thermal_fan_speed_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tfsc_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tfsc_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [11:0]          cfg_data_i
);
  import tfsc_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    StIdle   = 10'b0000000001,
    StDecode = 10'b0000000010,
    StCmpOn  = 10'b0000000100,
    StCmpOff = 10'b0000001000,
    StSpan   = 10'b0000010000,
    StMul1   = 10'b0000100000,
    StMul2   = 10'b0001000000,
    StAdd    = 10'b0010000000,
    StDiv    = 10'b0100000000,
    StOut    = 10'b1000000000
  } state_e;

  localparam logic [2:0] DivTop = 3'd7;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [11:0] on_q, off_q, full_q;
  logic [6:0]         high_q, low_q, step_q;

  // Controller state.
  logic [6:0] speed_q, speed_d;
  logic       manual_q, manual_d;
  logic       auto_q, auto_d;

  // Working registers of one item.
  in_item_t           item_q, item_d;
  logic signed [11:0] g_q, g_d;
  logic [12:0]        diff_q, diff_d;
  logic [12:0]        span_q, span_d;
  logic [6:0]         floor_q, floor_d;
  logic               start_on_q, start_on_d;
  logic               ge_on_q, ge_on_d;
  logic [20:0]        prod_q, prod_d;
  logic [AluW-1:0]    acc_q, acc_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [5:0]         quo_q, quo_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // Shared adder and multiplier operands.
  logic [AluW-1:0] alu_a, alu_b, alu_res;
  logic            alu_sub, alu_neg;
  logic [12:0]     mul_a;
  logic [7:0]      mul_b;
  logic [20:0]     mul_p;

  logic            in_accept;
  logic            out_free;
  logic [AluW-1:0] span_shift;
  logic [6:0]      quo_full;
  logic [7:0]      key_sum;
  logic [14:0]     pwm_prod;
  logic [30:0]     pwm_scaled;
  logic [7:0]      pwm_duty;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  tfsc_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  // The shared multiplier of the curve; both uses are sign-correct modulo 2^21.
  assign mul_p = {{8{mul_a[12]}}, mul_a} * {{13{mul_b[7]}}, mul_b};

  assign span_shift = {{(AluW-13){span_q[12]}}, span_q} << cnt_q;
  assign quo_full   = {quo_q, !alu_neg};
  assign key_sum    = {1'b0, speed_q} + {1'b0, step_q};

  // PWM duty: 0 at zero speed, else 100 + speed * 155 / 100, with the quotient
  // by 100 taken as a multiply by the reciprocal and a shift.
  assign pwm_prod   = {8'b0, speed_q} * {7'b0, PwmSpan};
  assign pwm_scaled = {16'b0, pwm_prod} * {15'b0, PwmRecip};
  assign pwm_duty   = (speed_q == 7'd0) ? 8'd0 : PwmBase + pwm_scaled[29:22];

  // Operand selection for the shared units.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    mul_a   = diff_q;
    mul_b   = {1'b0, MaxSpeed} - {1'b0, floor_q};
    case (state_q)
      StDecode: begin
        alu_a = {{(AluW-12){item_q.driver_temp[11]}}, item_q.driver_temp};
        alu_b = {{(AluW-12){item_q.regulator_temp[11]}}, item_q.regulator_temp};
      end
      StCmpOn: begin
        alu_a = {{(AluW-12){g_q[11]}}, g_q};
        alu_b = {{(AluW-12){on_q[11]}}, on_q};
      end
      StCmpOff: begin
        alu_a = {{(AluW-12){g_q[11]}}, g_q};
        alu_b = {{(AluW-12){off_q[11]}}, off_q};
      end
      StSpan: begin
        alu_a = {{(AluW-12){full_q[11]}}, full_q};
        alu_b = start_on_q ? {{(AluW-12){on_q[11]}}, on_q}
                           : {{(AluW-12){off_q[11]}}, off_q};
      end
      StMul2: begin
        mul_a = span_q;
        mul_b = {1'b0, floor_q};
      end
      StAdd: begin
        alu_a   = acc_q;
        alu_b   = {{(AluW-21){prod_q[20]}}, prod_q};
        alu_sub = 1'b0;
      end
      StDiv: begin
        alu_a = acc_q;
        alu_b = span_shift;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    speed_d     = speed_q;
    manual_d    = manual_q;
    auto_d      = auto_q;
    item_d      = item_q;
    g_d         = g_q;
    diff_d      = diff_q;
    span_d      = span_q;
    floor_d     = floor_q;
    start_on_d  = start_on_q;
    ge_on_d     = ge_on_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          item_d  = in_item_i;
          state_d = StDecode;
        end
      end
      StDecode: begin
        state_d = StOut;
        case (item_q.op)
          OpSample: begin
            // The hotter sensor drives the curve; manual mode ignores samples.
            g_d = alu_neg ? item_q.regulator_temp : item_q.driver_temp;
            if (!manual_q) begin
              state_d = StCmpOn;
            end
          end
          OpToggle: begin
            if (speed_q != MaxSpeed) begin
              manual_d = 1'b1;
              speed_d  = MaxSpeed;
            end else begin
              manual_d = 1'b0;
              speed_d  = 7'd0;
            end
          end
          OpDecrease: begin
            if (speed_q <= step_q) begin
              manual_d = 1'b0;
              speed_d  = 7'd0;
            end else begin
              manual_d = 1'b1;
              speed_d  = speed_q - step_q;
            end
          end
          OpIncrease: begin
            manual_d = 1'b1;
            speed_d  = (key_sum >= {1'b0, MaxSpeed}) ? MaxSpeed : key_sum[6:0];
          end
          default: begin
          end
        endcase
      end
      StCmpOn: begin
        ge_on_d = !alu_neg;
        diff_d  = alu_res[12:0];
        state_d = StCmpOff;
      end
      StCmpOff: begin
        // Hysteresis: on at or above the on threshold, off below the off threshold;
        // in between a running fan takes the low curve and a stopped fan stays off.
        if (ge_on_q) begin
          auto_d     = 1'b1;
          start_on_d = 1'b1;
          floor_d    = high_q;
          state_d    = StSpan;
        end else if (alu_neg) begin
          auto_d  = 1'b0;
          speed_d = 7'd0;
          state_d = StOut;
        end else if (auto_q) begin
          start_on_d = 1'b0;
          floor_d    = low_q;
          diff_d     = alu_res[12:0];
          state_d    = StSpan;
        end else begin
          state_d = StOut;
        end
      end
      StSpan: begin
        span_d  = alu_res[12:0];
        state_d = StMul1;
      end
      StMul1: begin
        // An empty or reversed span gives full speed.
        if (span_q[12] || (span_q == 13'd0)) begin
          speed_d = MaxSpeed;
          state_d = StOut;
        end else begin
          prod_d  = mul_p;
          state_d = StMul2;
        end
      end
      StMul2: begin
        acc_d   = {{(AluW-21){prod_q[20]}}, prod_q};
        prod_d  = mul_p;
        state_d = StAdd;
      end
      StAdd: begin
        acc_d   = alu_res;
        cnt_d   = DivTop;
        state_d = StDiv;
      end
      StDiv: begin
        if (cnt_q == DivTop) begin
          // First step: a non-positive numerator means zero speed, and a
          // quotient of 128 or more saturates.
          if (acc_q[AluW-1] || (acc_q == '0)) begin
            speed_d = 7'd0;
            state_d = StOut;
          end else if (!alu_neg) begin
            speed_d = MaxSpeed;
            state_d = StOut;
          end else begin
            quo_d = 6'd0;
            cnt_d = cnt_q - 3'd1;
          end
        end else begin
          if (!alu_neg) begin
            acc_d = alu_res;
          end
          if (cnt_q == 3'd0) begin
            speed_d = (quo_full > MaxSpeed) ? MaxSpeed : quo_full;
            state_d = StOut;
          end else begin
            quo_d = {quo_q[4:0], !alu_neg};
            cnt_d = cnt_q - 3'd1;
          end
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.fan_percent   = speed_q;
          out_item_d.pwm_duty      = pwm_duty;
          out_item_d.manual_active = manual_q;
          out_item_d.auto_running  = auto_q;
          state_d                  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      speed_q     <= 7'd0;
      manual_q    <= 1'b0;
      auto_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      manual_q    <= manual_d;
      auto_q      <= auto_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q   <= OnTempRst;
      off_q  <= OffTempRst;
      full_q <= FullTempRst;
      high_q <= HighFloorRst;
      low_q  <= LowFloorRst;
      step_q <= StepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        RegOnTemp:    on_q   <= cfg_data_i;
        RegOffTemp:   off_q  <= cfg_data_i;
        RegFullTemp:  full_q <= cfg_data_i;
        RegHighFloor: high_q <= cfg_data_i[6:0];
        RegLowFloor:  low_q  <= cfg_data_i[6:0];
        RegStep:      step_q <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    g_q        <= g_d;
    diff_q     <= diff_d;
    span_q     <= span_d;
    floor_q    <= floor_d;
    start_on_q <= start_on_d;
    ge_on_q    <= ge_on_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    cnt_q      <= cnt_d;
    quo_q      <= quo_d;
    out_item_q <= out_item_d;
  end

endmodule

### test/thermal_fan_speed_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_fan_speed_controller_tb: self-checking bench of the fan controller
// A queue of sample and key items feeds a clocked driver. The driver predicts
// each accepted item's speed, duty and mode flags with its own copy of the
// hysteresis state and the registers. A clocked monitor compares every
// output item with the oldest prediction. Random gaps and stalls are applied
// on both sides. The register set is changed between phases, and the extreme
// settings are among them.
// ----------------------------------------------------------------------------
module thermal_fan_speed_controller_tb;
  import tfsc_pkg::*;

  // Integer copies of the package constants, so that curve arithmetic stays
  // signed.
  localparam int SpeedCap = MaxSpeed;
  localparam int DutyBase = PwmBase;
  localparam int DutySpan = PwmSpan;
  // Register indexes past the last register. Writes to them must be dropped.
  localparam logic [2:0] SpareIdxLo = 3'd6;
  localparam logic [2:0] SpareIdxHi = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  thermal_fan_speed_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // The bench's own view of the registers. They start at their reset values
  // and follow every accepted write.
  logic signed [11:0] on_thr   = OnTempRst;
  logic signed [11:0] off_thr  = OffTempRst;
  logic signed [11:0] full_thr = FullTempRst;
  logic [6:0]         hi_floor = HighFloorRst;
  logic [6:0]         lo_floor = LowFloorRst;
  logic [6:0]         key_step = StepRst;

  // The bench's view of the controller state. Reset clears all of it.
  int pred_speed = 0;
  bit fan_manual = 1'b0;
  bit fan_auto   = 1'b0;

  in_item_t  item_backlog[$];      // items waiting for the driver
  out_item_t fan_results_due[$];   // predicted outputs, oldest first

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int send_gap  = 0;
  int recv_hold = 0;
  int fail_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Each curve is the floor plus the rise toward 100 over the span up to
  // full_temp, formed as one truncated quotient and then clamped to 0..100.
  // A span that is empty or reversed runs the fan at full speed.
  function automatic int curve_speed(int hot, int start, int floor_pct);
    int span;
    int num;
    int quot;
    span = int'(full_thr) - start;
    if (span <= 0) return SpeedCap;
    num = (hot - start) * (SpeedCap - floor_pct) + floor_pct * span;
    if (num <= 0) return 0;
    quot = num / span;
    return (quot > SpeedCap) ? SpeedCap : quot;
  endfunction

  // Applies one accepted item to the predicted state and returns the output
  // item that it should produce.
  function automatic out_item_t next_fan_state(in_item_t it);
    out_item_t res;
    int hot;
    int step;
    step = key_step;
    case (it.op)
      OpSample: begin
        // While a manual override holds the speed, samples are dropped.
        if (!fan_manual) begin
          hot = ($signed(it.driver_temp) >= $signed(it.regulator_temp)) ?
                $signed(it.driver_temp) : $signed(it.regulator_temp);
          if (hot >= on_thr) begin
            fan_auto   = 1'b1;
            pred_speed = curve_speed(hot, on_thr, hi_floor);
          end else if (hot < off_thr) begin
            pred_speed = 0;
            fan_auto   = 1'b0;
          end
          // Inside the hysteresis band a running fan follows the low curve;
          // a stopped fan keeps its speed.
          if (fan_auto && hot < on_thr) pred_speed = curve_speed(hot, off_thr, lo_floor);
        end
      end
      OpToggle: begin
        if (pred_speed != SpeedCap) begin
          fan_manual = 1'b1;
          pred_speed = SpeedCap;
        end else begin
          fan_manual = 1'b0;
          pred_speed = 0;
        end
      end
      OpDecrease: begin
        // Stepping down to zero hands control back to the automatic curve.
        if (pred_speed <= step) begin
          fan_manual = 1'b0;
          pred_speed = 0;
        end else begin
          fan_manual = 1'b1;
          pred_speed = pred_speed - step;
        end
      end
      default: begin
        fan_manual = 1'b1;
        pred_speed = pred_speed + step;
        if (pred_speed >= SpeedCap) pred_speed = SpeedCap;
      end
    endcase
    res.fan_percent   = 7'(pred_speed);
    res.pwm_duty      = (pred_speed == 0) ? 8'd0 :
                        8'(DutyBase + pred_speed * DutySpan / SpeedCap);
    res.manual_active = fan_manual;
    res.auto_running  = fan_auto;
    return res;
  endfunction

  // Driver. When an item is accepted, it predicts the result, then draws the
  // gap before the next item. A payload that is held stays unchanged.
  always @(posedge clk_i) begin : feed_items
    logic took;
    if (rst_ni) begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        fan_results_due.push_back(next_fan_state(in_item_i));
        send_gap = send_idle_on ? $urandom_range(0, 13) : 0;
      end
      if (took || !in_valid_i) begin
        if (send_gap == 0 && item_backlog.size() != 0) begin
          in_item_i  <= item_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
          if (send_gap != 0) send_gap--;
        end
      end
    end
  end

  // Monitor. Every accepted output item is checked field by field against
  // the oldest prediction. After each item, the stall is held for a drawn
  // number of cycles in which a result is on offer.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (fan_results_due.size() == 0) begin
          $error("output item with no prediction pending: %p", out_item_o);
          fail_count++;
        end else begin
          want = fan_results_due.pop_front();
          if (out_item_o.fan_percent !== want.fan_percent) begin
            $error("fan_percent: expected %0d, got %0d", want.fan_percent,
                   out_item_o.fan_percent);
            fail_count++;
          end
          if (out_item_o.pwm_duty !== want.pwm_duty) begin
            $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, out_item_o.pwm_duty);
            fail_count++;
          end
          if (out_item_o.manual_active !== want.manual_active) begin
            $error("manual_active: expected %0d, got %0d", want.manual_active,
                   out_item_o.manual_active);
            fail_count++;
          end
          if (out_item_o.auto_running !== want.auto_running) begin
            $error("auto_running: expected %0d, got %0d", want.auto_running,
                   out_item_o.auto_running);
            fail_count++;
          end
        end
        recv_hold = recv_idle_on ? $urandom_range(0, 13) : 0;
      end else if (out_valid_o && recv_hold > 0) begin
        recv_hold--;
      end
      out_stall_i <= (recv_hold != 0);
    end
  end

  task automatic push_item(op_e op, logic [11:0] drv, logic [11:0] reg_t);
    in_item_t it;
    it.op             = op;
    it.driver_temp    = drv;
    it.regulator_temp = reg_t;
    item_backlog.push_back(it);
  endtask

  // Returns once every queued item has gone out and every prediction has
  // been matched. It is checked on the falling edge, when everything has
  // settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (item_backlog.size() != 0 || in_valid_i || fan_results_due.size() != 0);
  endtask

  // One register write. Once the handshake is done, the bench's copy takes
  // the value. Indexes past the last register leave everything as it is.
  task automatic write_reg(logic [2:0] idx, logic [11:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      RegOnTemp:    on_thr   = data;
      RegOffTemp:   off_thr  = data;
      RegFullTemp:  full_thr = data;
      RegHighFloor: hi_floor = data[6:0];
      RegLowFloor:  lo_floor = data[6:0];
      RegStep:      key_step = data[6:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_regs(logic [11:0] v_on, logic [11:0] v_off, logic [11:0] v_full,
                           logic [11:0] v_hi, logic [11:0] v_lo, logic [11:0] v_step);
    write_reg(RegOnTemp, v_on);
    write_reg(RegOffTemp, v_off);
    write_reg(RegFullTemp, v_full);
    write_reg(RegHighFloor, v_hi);
    write_reg(RegLowFloor, v_lo);
    write_reg(RegStep, v_step);
  endtask

  // Random items. Most are samples placed close to one of the thresholds,
  // so that the hysteresis band and both curves are crossed often. The rest
  // are samples over the full range and manual keys. Keys carry random
  // temperatures, which the block must ignore.
  task automatic run_random(int count);
    in_item_t it;
    int pick;
    int base;
    int t;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) it.op = OpSample;
      else if (pick < 75) it.op = OpToggle;
      else if (pick < 88) it.op = OpDecrease;
      else it.op = OpIncrease;
      for (int k = 0; k < 2; k++) begin
        case ($urandom_range(0, 3))
          0: base = on_thr;
          1: base = off_thr;
          2: base = full_thr;
          default: base = $signed(12'($urandom));
        endcase
        t = base + int'($urandom_range(0, 96)) - 48;
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;
        if (k == 0) it.driver_temp = 12'(t);
        else it.regulator_temp = 12'(t);
      end
      item_backlog.push_back(it);
    end
    // The sender holds off here until every result has been seen.
    wait_drained();
  endtask

  initial begin : stimulus
    int t_on;
    int t_off;
    int t_full;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset settings (on 592, off 528, full 720,
    // floors 50 and 30, step 20).
    push_item(OpSample, 12'sd0, 12'sd0);           // cold: fan stays off
    push_item(OpSample, 12'sd560, 12'h800);        // inside the band while off: hold
    push_item(OpSample, 12'h800, 12'sd592);        // hotter sensor exactly at on
    push_item(OpSample, 12'sd2047, 12'h800);       // far above full: clamp to 100
    push_item(OpSample, 12'sd560, 12'sd560);       // inside the band while on: low curve
    push_item(OpSample, 12'sd528, 12'sd0);         // exactly at off while on
    push_item(OpSample, 12'sd527, 12'sd527);       // just below off: fan stops
    push_item(OpSample, 12'sd720, 12'sd720);       // exactly at full
    push_item(OpSample, 12'sd2047, 12'sd2047);
    push_item(OpDecrease, 12'($urandom), 12'($urandom));
    push_item(OpSample, 12'hFFF, 12'hFFF);         // manual mode: sample ignored
    push_item(OpIncrease, 12'($urandom), 12'($urandom));
    push_item(OpIncrease, 12'($urandom), 12'($urandom));  // saturates at 100
    push_item(OpToggle, 12'($urandom), 12'($urandom));    // from 100: back to auto, 0
    push_item(OpToggle, 12'($urandom), 12'($urandom));    // to full speed
    repeat (5) push_item(OpDecrease, 12'($urandom), 12'($urandom));  // down to zero
    push_item(OpDecrease, 12'($urandom), 12'($urandom));  // already at zero
    push_item(OpIncrease, 12'($urandom), 12'($urandom));
    push_item(OpToggle, 12'($urandom), 12'($urandom));
    push_item(OpDecrease, 12'($urandom), 12'($urandom));
    push_item(OpToggle, 12'($urandom), 12'($urandom));
    push_item(OpToggle, 12'($urandom), 12'($urandom));
    wait_drained();

    // Random phases, each with its own register settings and idling mix.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          load_regs(OnTempRst, OffTempRst, FullTempRst, 12'(HighFloorRst),
                    12'(LowFloorRst), 12'(StepRst));
          write_reg(SpareIdxLo, 12'($urandom));
          write_reg(SpareIdxHi, 12'($urandom));
        end
        // Highest on threshold with off and full at the bottom: both spans are
        // empty or reversed; floors and step are at their widest, every bit set.
        1: load_regs(12'sd2047, 12'h800, 12'h800, 12'hFFF, 12'hFFF, 12'hFFF);
        // Lowest thresholds, widest span, zero floors and a zero step.
        2: load_regs(12'h800, 12'h800, 12'sd2047, 12'hF80, 12'hF80, 12'hF80);
        6: load_regs(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 12'($urandom));
        default: begin
          t_on   = int'($urandom_range(0, 3000)) - 1500;
          t_off  = t_on - int'($urandom_range(0, 150));
          t_full = t_on + int'($urandom_range(1, 300));
          load_regs(12'(t_on), 12'(t_off), 12'(t_full),
                    {5'($urandom), 7'($urandom_range(0, 100))},
                    {5'($urandom), 7'($urandom_range(0, 100))},
                    {5'($urandom), 7'($urandom_range(1, 100))});
        end
      endcase
      send_idle_on = (p % 3) != 1;
      recv_idle_on = (p % 3) != 2 && p != 4;
      repeat (3) run_random(38);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fan_results_due.size() != 0) begin
      $error("%0d predicted output items never arrived", fan_results_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("thermal_fan_speed_controller_tb: clean");
    end else begin
      $display("thermal_fan_speed_controller_tb: errors");
    end
    $finish;
  end

  // Guard against a hung handshake. The slowest correct run stays well below
  // this limit.
  initial begin : watchdog
    #5_000_000;
    $display("thermal_fan_speed_controller_tb: errors");
    $finish;
  end

endmodule

### sim.f
sv/tfsc_pkg.sv
sv/tfsc_alu.sv
sv/thermal_fan_speed_controller.sv
test/thermal_fan_speed_controller_tb.sv
